@@ rtl/core/swpw_pkg.sv @@
// Shared types and constants for the single-wire pulse-width transceiver.
package swpw_pkg;

	// Configuration register indexes
	localparam logic [1:0] REG_TICKS_PER_US   = 2'd0;
	localparam logic [1:0] REG_SAMPLE_DELAY   = 2'd1;
	localparam logic [1:0] REG_EDGE_TIMEOUT   = 2'd2;
	localparam logic [1:0] REG_RX_BIT_COUNT   = 2'd3;

	localparam int CfgIndexWidth = 2;
	localparam int CfgDataWidth  = 16;

	// Register reset values
	localparam logic [7:0]  TICKS_PER_US_RST = 8'd16;
	localparam logic [9:0]  SAMPLE_DELAY_RST = 10'd32;
	localparam logic [15:0] EDGE_TIMEOUT_RST = 16'd252;
	localparam logic [6:0]  RX_BIT_COUNT_RST = 7'd32;

	// Receive length cap and last bit of a byte
	localparam logic [6:0] RX_MAX_BITS   = 7'd64;
	localparam logic [2:0] BYTE_LAST_BIT = 3'd7;
	localparam logic [1:0] SLOT_LAST     = 2'd3;

	typedef enum logic [2:0] {
		PH_IDLE         = 3'd0,
		PH_SEND_BIT     = 3'd1,
		PH_SEND_STOP    = 3'd2,
		PH_RX_WAIT_LOW  = 3'd3,
		PH_RX_DELAY     = 3'd4,
		PH_RX_WAIT_HIGH = 3'd5
	} phase_t;

	typedef struct packed {
		logic [7:0]  ticks_per_microsecond;
		logic [9:0]  sample_delay_ticks;
		logic [15:0] edge_timeout_ticks;
		logic [6:0]  receive_bit_count;
	} cfg_t;

	typedef struct packed {
		logic       line_level;
		logic       send_valid;
		logic [7:0] send_byte;
		logic       send_final;
		logic       receive_request;
	} in_word_t;

	typedef struct packed {
		logic drive_low;
		logic byte_taken;
		logic send_finished;
		logic send_underrun;
		logic bit_valid;
		logic bit_value;
		logic receive_finished;
		logic receive_timeout;
		logic busy_res;
	} out_word_t;

endpackage

@@ rtl/core/swpw_core.sv @@
// Line coding state machine: one tick of send or receive timing per step.
module swpw_core import swpw_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  in_word_t  word,
	input  cfg_t      cfg,
	output out_word_t res
);

	phase_t      phase_q, phase_d;
	logic [15:0] tick_q, tick_d;
	logic [1:0]  slot_q, slot_d;
	logic [2:0]  bit_idx_q, bit_idx_d;
	logic [7:0]  shift_q, shift_d;
	logic        final_q, final_d;
	logic [6:0]  rx_cnt_q, rx_cnt_d;

	logic [15:0] tick_inc;
	logic [15:0] tpu;
	logic [15:0] sample_lim;
	logic [15:0] edge_lim;
	logic [6:0]  want;
	logic [6:0]  rx_cnt_inc;
	logic        slot_end;
	logic        edge_expired;
	logic        sample_now;

	// Effective register values: zero acts as one, bit count capped
	always_comb begin
		tpu        = (cfg.ticks_per_microsecond == 8'd0) ? 16'd1
		             : {8'd0, cfg.ticks_per_microsecond};
		sample_lim = (cfg.sample_delay_ticks == 10'd0) ? 16'd1
		             : {6'd0, cfg.sample_delay_ticks};
		edge_lim   = (cfg.edge_timeout_ticks == 16'd0) ? 16'd1
		             : cfg.edge_timeout_ticks;
		if (cfg.receive_bit_count == 7'd0)
			want = 7'd1;
		else if (cfg.receive_bit_count > RX_MAX_BITS)
			want = RX_MAX_BITS;
		else
			want = cfg.receive_bit_count;
	end

	assign tick_inc     = tick_q + 16'd1;
	assign rx_cnt_inc   = rx_cnt_q + 7'd1;
	assign slot_end     = (tick_inc >= tpu);
	assign edge_expired = (tick_inc >= edge_lim);
	assign sample_now   = (tick_inc >= sample_lim);

	// Next state
	always_comb begin
		phase_d   = phase_q;
		tick_d    = tick_q;
		slot_d    = slot_q;
		bit_idx_d = bit_idx_q;
		shift_d   = shift_q;
		final_d   = final_q;
		rx_cnt_d  = rx_cnt_q;
		unique case (phase_q)
			PH_IDLE: begin
				if (word.send_valid) begin
					shift_d   = word.send_byte;
					final_d   = word.send_final;
					bit_idx_d = 3'd0;
					slot_d    = 2'd0;
					tick_d    = 16'd0;
					phase_d   = PH_SEND_BIT;
				end else if (word.receive_request) begin
					tick_d   = 16'd0;
					rx_cnt_d = 7'd0;
					phase_d  = PH_RX_WAIT_LOW;
				end
			end
			PH_SEND_BIT: begin
				tick_d = tick_inc;
				if (slot_end) begin
					tick_d = 16'd0;
					if (slot_q != SLOT_LAST) begin
						slot_d = slot_q + 2'd1;
					end else begin
						slot_d = 2'd0;
						if (bit_idx_q != BYTE_LAST_BIT) begin
							bit_idx_d = bit_idx_q + 3'd1;
							shift_d   = {shift_q[6:0], 1'b0};
						end else begin
							bit_idx_d = 3'd0;
							if (!final_q && word.send_valid) begin
								shift_d = word.send_byte;
								final_d = word.send_final;
							end else begin
								phase_d = PH_SEND_STOP;
							end
						end
					end
				end
			end
			PH_SEND_STOP: begin
				if (tick_q >= tpu) begin
					tick_d  = 16'd0;
					phase_d = PH_IDLE;
				end else begin
					tick_d = tick_inc;
				end
			end
			PH_RX_WAIT_LOW: begin
				if (!word.line_level) begin
					tick_d  = 16'd0;
					phase_d = PH_RX_DELAY;
				end else if (edge_expired) begin
					tick_d  = 16'd0;
					phase_d = PH_IDLE;
				end else begin
					tick_d = tick_inc;
				end
			end
			PH_RX_DELAY: begin
				tick_d = tick_inc;
				if (sample_now) begin
					tick_d   = 16'd0;
					rx_cnt_d = rx_cnt_inc;
					phase_d  = (rx_cnt_inc >= want) ? PH_IDLE : PH_RX_WAIT_HIGH;
				end
			end
			PH_RX_WAIT_HIGH: begin
				if (word.line_level) begin
					tick_d  = 16'd0;
					phase_d = PH_RX_WAIT_LOW;
				end else if (edge_expired) begin
					tick_d  = 16'd0;
					phase_d = PH_IDLE;
				end else begin
					tick_d = tick_inc;
				end
			end
			default: begin
				tick_d  = 16'd0;
				phase_d = PH_IDLE;
			end
		endcase
	end

	// Result word for this tick
	always_comb begin
		res = '0;
		unique case (phase_q)
			PH_IDLE: begin
				res.byte_taken = word.send_valid;
			end
			PH_SEND_BIT: begin
				// a one is low for slot 0 only, a zero for slots 0..2
				res.drive_low = (slot_q == 2'd0) || (!shift_q[7] && slot_q != SLOT_LAST);
				if (slot_end && slot_q == SLOT_LAST && bit_idx_q == BYTE_LAST_BIT) begin
					res.byte_taken    = !final_q && word.send_valid;
					res.send_underrun = !final_q && !word.send_valid;
				end
			end
			PH_SEND_STOP: begin
				res.send_finished = (tick_q >= tpu);
				res.drive_low     = !(tick_q >= tpu);
			end
			PH_RX_WAIT_LOW: begin
				res.receive_timeout = word.line_level && edge_expired;
			end
			PH_RX_DELAY: begin
				res.bit_valid        = sample_now;
				res.bit_value        = sample_now && word.line_level;
				res.receive_finished = sample_now && (rx_cnt_inc >= want);
			end
			PH_RX_WAIT_HIGH: begin
				res.receive_timeout = !word.line_level && edge_expired;
			end
			default: begin
				res.drive_low = 1'b0;
			end
		endcase
		res.busy_res = (phase_q != PH_IDLE) || (phase_d != PH_IDLE);
	end

	// State registers advance once per processed tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			tick_q    <= '0;
			slot_q    <= '0;
			bit_idx_q <= '0;
			shift_q   <= '0;
			final_q   <= 1'b0;
			rx_cnt_q  <= '0;
		end else if (step) begin
			phase_q   <= phase_d;
			tick_q    <= tick_d;
			slot_q    <= slot_d;
			bit_idx_q <= bit_idx_d;
			shift_q   <= shift_d;
			final_q   <= final_d;
			rx_cnt_q  <= rx_cnt_d;
		end
	end

	// A stop bit only ever follows a byte boundary inside a send
	a_stop_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(step && phase_d == PH_SEND_STOP && phase_q != PH_SEND_STOP)
			|=> ($past(phase_q) == PH_SEND_BIT))
		else $error("stop bit entered from a non-send phase");

	// Receive finish only comes with a presented bit
	a_fin_bit: assert property (@(posedge clk) disable iff (!arst_n)
		res.receive_finished |-> res.bit_valid)
		else $error("receive finished without a bit");

	// Received count never passes the cap while receiving
	a_rx_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_RX_WAIT_LOW || phase_q == PH_RX_DELAY
			|| phase_q == PH_RX_WAIT_HIGH) |-> (rx_cnt_q < RX_MAX_BITS))
		else $error("receive count past cap");

	// Timeout and sampled bit never land on the same tick
	a_to_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(res.receive_timeout && res.bit_valid))
		else $error("timeout together with a bit");

endmodule

@@ rtl/core/single_wire_pulse_width_transceiver_top.sv @@
// Top level: input register, line coding core, result register, config registers.
//
//  channel | direction | handshake          | payload
//  in      | to block  | in_valid/in_stall   | in_word  (one clock tick of line state)
//  out     | from block| out_valid/out_stall | out_word (drive and strobes for that tick)
//  cfg     | to block  | cfg_we              | cfg_index, cfg_data
//
// One word per cycle sustained while out_stall is low; a taken word passes through the
// input register, then result register, the core state advancing as it leaves stage one.
// Reset clears all control state and loads the register reset values.
// A stalled output holds its word; the input register still takes one word behind it,
// after which in_stall rises until the output moves.
module single_wire_pulse_width_transceiver_top import swpw_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  in_word_t                 in_word,
	output logic                     out_valid,
	input  logic                     out_stall,
	output out_word_t                out_word,
	input  logic                     cfg_we,
	input  logic [CfgIndexWidth-1:0] cfg_index,
	input  logic [CfgDataWidth-1:0]  cfg_data
);

	cfg_t      cfg_q;
	logic      valid_s1;
	in_word_t  word_s1;
	logic      out_valid_q;
	out_word_t out_word_q;
	out_word_t res;
	logic      advance;

	// Stage one moves on when the result register is free or draining
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ticks_per_microsecond <= TICKS_PER_US_RST;
			cfg_q.sample_delay_ticks    <= SAMPLE_DELAY_RST;
			cfg_q.edge_timeout_ticks    <= EDGE_TIMEOUT_RST;
			cfg_q.receive_bit_count     <= RX_BIT_COUNT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TICKS_PER_US: cfg_q.ticks_per_microsecond <= cfg_data[7:0];
				REG_SAMPLE_DELAY: cfg_q.sample_delay_ticks    <= cfg_data[9:0];
				REG_EDGE_TIMEOUT: cfg_q.edge_timeout_ticks    <= cfg_data;
				REG_RX_BIT_COUNT: cfg_q.receive_bit_count     <= cfg_data[6:0];
				default:          cfg_q                       <= cfg_q;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			word_s1 <= in_word;
		end
	end

	swpw_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.word   (word_s1),
		.cfg    (cfg_q),
		.res    (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_word_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

endmodule
